// File: hw/rtl/aopc_pkg.sv
`timescale 1ns / 1ps
package aopc_pkg;

   localparam int RAW_W             = 10;
   localparam int OUT_W             = 11;
   localparam int ORIENT_W          = 3;
   localparam int EVENT_W           = 3;
   localparam int FUNC_W            = 2;
   localparam int NUM_AXES          = 3;
   localparam int AVG_SHIFT_DEFAULT = 5;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 3;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = FUNC_W;
   localparam int RSP_TDATA_W = 40;

   // register index of the mounting orientation
   localparam logic [CSR_ADDR_W-3:0] CSR_ORIENT_IDX = '0;

   localparam logic [ORIENT_W-1:0] ORIENT_FORWARD     = 3'd0;
   localparam logic [ORIENT_W-1:0] ORIENT_VERTICAL    = 3'd1;
   localparam logic [ORIENT_W-1:0] ORIENT_UPSIDE_DOWN = 3'd2;
   localparam logic [ORIENT_W-1:0] ORIENT_AFT         = 3'd3;
   localparam logic [ORIENT_W-1:0] ORIENT_SIDEWAYS    = 3'd4;

   localparam logic [RAW_W-1:0] YAW_MID_DEFAULT  = 10'd640;
   localparam logic [RAW_W-1:0] YAW_MID_VERTICAL = 10'd615;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ  = 2'd0,
      FUNC_LEVEL = 2'd1,
      FUNC_INV   = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE       = 3'd0,
      EV_LEVEL_DONE = 3'd1,
      EV_INV_DONE   = 3'd2,
      EV_INV_REJECT = 3'd3,
      EV_IGNORED    = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      RUN_NONE  = 2'd0,
      RUN_LEVEL = 2'd1,
      RUN_INV   = 2'd2
   } run_type;

   typedef struct packed {
      logic             read;
      logic             accum;
      logic             restart;
      logic             load_avg;
      logic             load_ext;
      logic [RAW_W-1:0] ext_value;
   } lane_ctl_type;

   typedef struct packed {
      event_type ev;
      logic      level;
      logic      inv;
   } status_type;

   // bit 0 roll, bit 1 pitch, bit 2 yaw: set where the axis is negated
   function automatic logic [NUM_AXES-1:0] axis_negate(input logic [ORIENT_W-1:0] orient);
      logic [NUM_AXES-1:0] neg;
      case (orient)
         ORIENT_VERTICAL:    neg = 3'b110;
         ORIENT_UPSIDE_DOWN: neg = 3'b101;
         ORIENT_AFT:         neg = 3'b011;
         ORIENT_SIDEWAYS:    neg = 3'b010;
         default:            neg = 3'b000;
      endcase
      return neg;
   endfunction

   function automatic logic [RAW_W-1:0] yaw_default(input logic [ORIENT_W-1:0] orient);
      return (orient == ORIENT_VERTICAL) ? YAW_MID_VERTICAL : YAW_MID_DEFAULT;
   endfunction

endpackage

// File: hw/rtl/aopc_lane.sv
`timescale 1ns / 1ps
module aopc_lane #(
   parameter int AVG_SHIFT = aopc_pkg::AVG_SHIFT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  aopc_pkg::lane_ctl_type            ctl,
   input  logic [aopc_pkg::RAW_W-1:0]        raw,
   input  logic                              negate,
   output logic signed [aopc_pkg::OUT_W-1:0] corr_out,
   output logic [aopc_pkg::RAW_W-1:0]        avg
);
   import aopc_pkg::*;

   localparam int SUM_W = RAW_W + AVG_SHIFT;

   logic [SUM_W-1:0]        sum_ff;
   logic [SUM_W-1:0]        sum_in;
   logic [RAW_W-1:0]        zero_ff;
   logic [RAW_W-1:0]        zero_in;
   logic signed [OUT_W-1:0] diff;
   logic signed [OUT_W-1:0] corr;

   // a fresh run starts from an empty sum
   assign sum_in = (ctl.restart ? '0 : sum_ff) + SUM_W'(raw);
   assign avg    = sum_in[AVG_SHIFT +: RAW_W];

   assign diff     = OUT_W'(raw) - OUT_W'(zero_ff);
   assign corr     = negate ? -diff : diff;
   assign corr_out = ctl.read ? corr : '0;

   always_comb begin
      zero_in = zero_ff;
      if (ctl.load_avg) begin
         zero_in = avg;
      end else if (ctl.load_ext) begin
         zero_in = ctl.ext_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= '0;
      end else begin
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accum) begin
         sum_ff <= sum_in;
      end
   end

endmodule

// File: hw/rtl/aopc_ctrl.sv
`timescale 1ns / 1ps
module aopc_ctrl #(
   parameter int AVG_SHIFT = aopc_pkg::AVG_SHIFT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  aopc_pkg::func_type            func,
   input  logic [aopc_pkg::ORIENT_W-1:0] orient,
   input  logic [aopc_pkg::RAW_W-1:0]    yaw_avg,
   output aopc_pkg::lane_ctl_type        ctl_xy,
   output aopc_pkg::lane_ctl_type        ctl_yaw,
   output aopc_pkg::status_type          status
);
   import aopc_pkg::*;

   localparam int CNT_W = AVG_SHIFT;

   logic             level_ff, level_in;
   logic             inv_ff, inv_in;
   run_type          run_ff, run_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [RAW_W-1:0] lyz_ff, lyz_in;

   logic [NUM_AXES-1:0] neg;
   logic [RAW_W-1:0]    dflt;
   run_type             kind;
   logic                restart;
   logic [CNT_W-1:0]    count_eff;
   logic                pass;
   logic [RAW_W:0]      mid_sum;

   assign neg       = axis_negate(orient);
   assign dflt      = yaw_default(orient);
   assign kind      = (func == FUNC_LEVEL) ? RUN_LEVEL : RUN_INV;
   assign restart   = (run_ff != kind);
   assign count_eff = restart ? '0 : count_ff;
   // inverted board reads past the default on the far side of its sign
   assign pass      = neg[2] ? (yaw_avg > dflt) : (yaw_avg < dflt);
   // ceil of the mean of level and inverted readings
   assign mid_sum   = (RAW_W+1)'(lyz_ff) + (RAW_W+1)'(yaw_avg) + (RAW_W+1)'(1);

   always_comb begin
      level_in = level_ff;
      inv_in   = inv_ff;
      run_in   = run_ff;
      count_in = count_ff;
      lyz_in   = lyz_ff;
      ctl_xy   = '0;
      ctl_yaw  = '0;
      status.ev = EV_NONE;

      unique case (func) inside
         FUNC_READ: begin
            ctl_xy.read  = fire;
            ctl_yaw.read = fire;
            if (!inv_ff) begin
               ctl_yaw.load_ext  = fire;
               ctl_yaw.ext_value = dflt;
            end
         end
         FUNC_LEVEL, FUNC_INV: begin
            if (func == FUNC_INV && !level_ff) begin
               status.ev = EV_IGNORED;
            end else begin
               ctl_xy.accum    = fire;
               ctl_yaw.accum   = fire;
               ctl_xy.restart  = restart;
               ctl_yaw.restart = restart;
               if (&count_eff) begin
                  run_in   = RUN_NONE;
                  count_in = '0;
                  if (kind == RUN_LEVEL) begin
                     ctl_xy.load_avg  = fire;
                     ctl_yaw.load_avg = fire;
                     lyz_in    = yaw_avg;
                     level_in  = 1'b1;
                     inv_in    = 1'b0;
                     status.ev = EV_LEVEL_DONE;
                  end else if (pass) begin
                     ctl_yaw.load_ext  = fire;
                     ctl_yaw.ext_value = mid_sum[RAW_W:1];
                     inv_in    = 1'b1;
                     level_in  = 1'b0;
                     status.ev = EV_INV_DONE;
                  end else begin
                     status.ev = EV_INV_REJECT;
                  end
               end else begin
                  run_in   = kind;
                  count_in = count_eff + CNT_W'(1);
               end
            end
         end
         default: begin
            status.ev = EV_IGNORED;
         end
      endcase

      status.level = level_in;
      status.inv   = inv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         inv_ff   <= 1'b0;
         run_ff   <= RUN_NONE;
         count_ff <= '0;
         lyz_ff   <= '0;
      end else if (fire) begin
         level_ff <= level_in;
         inv_ff   <= inv_in;
         run_ff   <= run_in;
         count_ff <= count_in;
         lyz_ff   <= lyz_in;
      end
   end

endmodule

// File: hw/rtl/accel_offset_polarity_calibrator_top.sv
`timescale 1ns / 1ps
// Accelerometer offset and polarity calibrator.
// Request channel (req_*): one three-axis 10-bit sample per request, with the
// function code on req_tuser: read, level calibration sample or inverted
// calibration sample. Response channel (rsp_*): one response per request,
// carrying the corrected axes, the calibration event and both done flags.
// Configuration (csr_*): the mounting orientation at byte address 0.
// The response is registered on the edge that accepts the request. Throughput
// is one request per cycle while no response is stalled; the per-item state
// update (three axis lanes accumulating and reloading their zeros, plus the
// calibration controller) is combinational and lands on that accepting edge.
// A stalled response is held in the output register; a new request is taken
// in the same cycle that the held response leaves, so req_tready drops only
// while a response waits and rsp_tready is low.
// Reset clears zeros, flags, run state, orientation; empties output register.
// The user must write orientation only while the block is idle (unenforced).
module accel_offset_polarity_calibrator_top #(
   parameter int AVG_SHIFT = aopc_pkg::AVG_SHIFT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [9:0] roll_raw, [19:10] pitch_raw, [29:20] yaw_raw, [31:30] zero
   input  logic [aopc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] func
   input  logic [aopc_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [10:0] roll_out, [21:11] pitch_out, [32:22] yaw_out, [35:33] cal_event,
   // [36] level_cal_flag, [37] inverted_cal_flag, [39:38] zero
   output logic [aopc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [aopc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [aopc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [aopc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import aopc_pkg::*;

   logic                   fire;
   logic [ORIENT_W-1:0]    orient_ff;
   logic                   csr_hit;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   func_type               func;
   logic [RAW_W-1:0]       raw [NUM_AXES];
   logic signed [OUT_W-1:0] corr [NUM_AXES];
   logic [RAW_W-1:0]       avg [NUM_AXES];
   logic [NUM_AXES-1:0]    neg;
   lane_ctl_type           ctl_xy;
   lane_ctl_type           ctl_yaw;
   lane_ctl_type           ctl_lane [NUM_AXES];
   status_type             status;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_ORIENT_IDX);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(orient_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= ORIENT_FORWARD;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         orient_ff <= csr_pwdata[ORIENT_W-1:0];
      end
   end

   // request side
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign func       = func_type'(req_tuser[FUNC_W-1:0]);
   assign neg        = axis_negate(orient_ff);

   assign ctl_lane[0] = ctl_xy;
   assign ctl_lane[1] = ctl_xy;
   assign ctl_lane[2] = ctl_yaw;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      assign raw[a] = req_tdata[a*RAW_W +: RAW_W];
      aopc_lane #(
         .AVG_SHIFT (AVG_SHIFT)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl_lane[a]),
         .raw      (raw[a]),
         .negate   (neg[a]),
         .corr_out (corr[a]),
         .avg      (avg[a])
      );
   end

   aopc_ctrl #(
      .AVG_SHIFT (AVG_SHIFT)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .func    (func),
      .orient  (orient_ff),
      .yaw_avg (avg[2]),
      .ctl_xy  (ctl_xy),
      .ctl_yaw (ctl_yaw),
      .status  (status)
   );

   // merge lane results with the controller status
   assign rsp_data_in = {2'b00, status.inv, status.level, status.ev,
                         corr[2], corr[1], corr[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
